// ===== hdl/ntfs_rld_pkg.sv =====
// ----------------------------------------------------------------------------
// ntfs_rld_pkg
// Shared types and constants of the run list decoder: request and result
// layouts, result kinds and decoder phases.
// ----------------------------------------------------------------------------
`default_nettype none

package ntfs_rld_pkg;

    // request opcodes
    localparam logic OP_START = 1'b0;
    localparam logic OP_BYTE  = 1'b1;

    // size nibble limit and sign bit of a delta byte
    localparam logic [3:0]  SIZE_MAX     = 4'd8;
    localparam logic [7:0]  SIGN_BIT     = 8'h80;
    localparam logic [13:0] LIMIT_RESET  = 14'd10000;
    localparam logic [14:0] EMITTED_MAX  = 15'h7FFF;

    typedef enum logic [1:0] {
        K_RANGE     = 2'd0,
        K_END       = 2'd1,
        K_MALFORMED = 2'd2,
        K_TRUNCATED = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_LENGTH  = 2'd1,
        PH_OFFSET  = 2'd2,
        PH_STOPPED = 2'd3
    } t_phase;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
        logic       last;
    } t_rld_in;

    typedef struct packed {
        t_kind        kind;
        logic [62:0]  run_start;
        logic [63:0]  run_count;
        logic         final_res;
    } t_rld_out;

endpackage

`default_nettype wire

// ===== hdl/ntfs_rld_in_stage.sv =====
// ----------------------------------------------------------------------------
// ntfs_rld_in_stage
// Input register: holds one request until the decoder core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ntfs_rld_in_stage (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_stall,
    input  ntfs_rld_pkg::t_rld_in  i_in,
    input  wire                    i_take,
    output logic                   o_valid,
    output ntfs_rld_pkg::t_rld_in  o_item
);
    import ntfs_rld_pkg::*;

    logic    r_valid;
    t_rld_in r_item;

    // stall only while a held request cannot move on this cycle
    assign o_in_stall = r_valid && !i_take;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_valid <= i_in_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_item <= i_in;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ntfs_rld_core.sv =====
// ----------------------------------------------------------------------------
// ntfs_rld_core
// Run list state and the per-byte decode: header check, length and delta
// gathering, cluster accumulation and range emission.
// ----------------------------------------------------------------------------
`default_nettype none

module ntfs_rld_core (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_we,
    input  wire  [13:0]            i_cfg_wdata,
    input  wire                    i_fire,
    input  ntfs_rld_pkg::t_rld_in  i_item,
    output logic                   o_res_valid,
    output ntfs_rld_pkg::t_rld_out o_res
);
    import ntfs_rld_pkg::*;

    logic [13:0] r_limit;
    t_phase      r_phase, n_phase;
    logic [3:0]  r_len_size, n_len_size;
    logic [3:0]  r_off_size, n_off_size;
    logic [2:0]  r_pos, n_pos;
    logic [63:0] r_run_length, n_run_length;
    logic [63:0] r_delta, n_delta;
    logic [63:0] r_cluster, n_cluster;
    logic [14:0] r_count, n_count;

    logic [7:0]  b;
    logic [3:0]  hdr_ls, hdr_os;
    logic        hdr_zero, hdr_bad;
    logic [2:0]  pos_inc;
    logic        len_done, off_done, ext_sign;
    logic [63:0] len_merged, delta_merged, delta_ext;
    logic [63:0] fin_delta, fin_length, cluster_sum;
    logic        emit, over, is_byte;
    logic [14:0] count_next;
    logic        do_finish;
    t_kind       res_kind;
    logic        res_fin;

    // header fields and field progress
    assign b        = i_item.data_byte;
    assign is_byte  = (i_item.op == OP_BYTE);
    assign hdr_ls   = b[3:0];
    assign hdr_os   = b[7:4];
    assign hdr_zero = (b == 8'd0);
    assign hdr_bad  = (hdr_ls == 4'd0) || (hdr_ls > SIZE_MAX) || (hdr_os > SIZE_MAX);
    assign pos_inc  = r_pos + 3'd1;
    assign len_done = (pos_inc == r_len_size[2:0]);
    assign off_done = (pos_inc == r_off_size[2:0]);
    assign ext_sign = ((b & SIGN_BIT) != 8'd0) && (r_off_size < SIZE_MAX);

    // byte lane insert and sign extension of the delta
    always_comb begin
        len_merged   = r_run_length;
        delta_merged = r_delta;
        for (int i = 0; i < 8; i++) begin
            if (r_pos == 3'(i)) begin
                len_merged[i*8 +: 8]   = b;
                delta_merged[i*8 +: 8] = b;
            end
        end
        delta_ext = delta_merged;
        for (int i = 0; i < 8; i++) begin
            if (ext_sign && (4'(i) >= r_off_size)) begin
                delta_ext[i*8 +: 8] = 8'hFF;
            end
        end
    end

    // run completion: cluster update, emission and limit check
    assign fin_delta   = (r_phase == PH_OFFSET) ? delta_ext : r_delta;
    assign fin_length  = (r_phase == PH_LENGTH) ? len_merged : r_run_length;
    assign cluster_sum = r_cluster + fin_delta;
    assign emit        = (r_off_size != 4'd0) && !cluster_sum[63] && (cluster_sum != 64'd0);
    assign count_next  = (emit && (r_count != EMITTED_MAX)) ? r_count + 15'd1 : r_count;
    assign over        = (count_next > {1'b0, r_limit});
    assign do_finish   = is_byte && (((r_phase == PH_LENGTH) && len_done
                                      && (r_off_size == 4'd0))
                                     || ((r_phase == PH_OFFSET) && off_done));

    // result of the current request
    always_comb begin
        o_res_valid = 1'b0;
        res_kind    = K_END;
        res_fin     = 1'b0;
        if (is_byte) begin
            unique case (r_phase)
                PH_HEADER: begin
                    if (hdr_zero) begin
                        o_res_valid = 1'b1;
                        res_kind    = K_END;
                        res_fin     = 1'b1;
                    end else if (hdr_bad) begin
                        o_res_valid = 1'b1;
                        res_kind    = K_MALFORMED;
                        res_fin     = 1'b1;
                    end else if (i_item.last) begin
                        o_res_valid = 1'b1;
                        res_kind    = K_TRUNCATED;
                        res_fin     = 1'b1;
                    end
                end
                PH_LENGTH, PH_OFFSET: begin
                    if (do_finish) begin
                        if (emit) begin
                            o_res_valid = 1'b1;
                            res_kind    = K_RANGE;
                            res_fin     = i_item.last || over;
                        end else if (i_item.last || over) begin
                            o_res_valid = 1'b1;
                            res_kind    = K_END;
                            res_fin     = 1'b1;
                        end
                    end else if (i_item.last) begin
                        o_res_valid = 1'b1;
                        res_kind    = K_TRUNCATED;
                        res_fin     = 1'b1;
                    end
                end
                PH_STOPPED: begin
                    o_res_valid = 1'b0;
                end
                default: begin
                    o_res_valid = 1'b0;
                end
            endcase
        end
        o_res.kind      = res_kind;
        o_res.run_start = (res_kind == K_RANGE) ? cluster_sum[62:0] : 63'd0;
        o_res.run_count = (res_kind == K_RANGE) ? fin_length : 64'd0;
        o_res.final_res = res_fin;
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (i_fire) begin
            if (!is_byte) begin
                n_phase = PH_HEADER;
            end else if (o_res_valid && res_fin) begin
                n_phase = PH_STOPPED;
            end else begin
                unique case (r_phase)
                    PH_HEADER:  n_phase = PH_LENGTH;
                    PH_LENGTH: begin
                        if (len_done) begin
                            n_phase = (r_off_size == 4'd0) ? PH_HEADER : PH_OFFSET;
                        end
                    end
                    PH_OFFSET: begin
                        if (off_done) begin
                            n_phase = PH_HEADER;
                        end
                    end
                    PH_STOPPED: n_phase = PH_STOPPED;
                    default:    n_phase = PH_STOPPED;
                endcase
            end
        end
    end

    // run fields and counters
    always_comb begin
        n_len_size   = r_len_size;
        n_off_size   = r_off_size;
        n_pos        = r_pos;
        n_run_length = r_run_length;
        n_delta      = r_delta;
        n_cluster    = r_cluster;
        n_count      = r_count;
        if (i_fire) begin
            if (!is_byte) begin
                n_len_size   = 4'd0;
                n_off_size   = 4'd0;
                n_pos        = 3'd0;
                n_run_length = 64'd0;
                n_delta      = 64'd0;
                n_cluster    = 64'd0;
                n_count      = 15'd0;
            end else begin
                unique case (r_phase)
                    PH_HEADER: begin
                        if (!hdr_zero && !hdr_bad && !i_item.last) begin
                            n_len_size   = hdr_ls;
                            n_off_size   = hdr_os;
                            n_pos        = 3'd0;
                            n_run_length = 64'd0;
                            n_delta      = 64'd0;
                        end
                    end
                    PH_LENGTH: begin
                        n_run_length = len_merged;
                        n_pos        = len_done ? 3'd0 : pos_inc;
                    end
                    PH_OFFSET: begin
                        n_delta = off_done ? delta_ext : delta_merged;
                        n_pos   = off_done ? 3'd0 : pos_inc;
                    end
                    PH_STOPPED: begin
                        n_pos = r_pos;
                    end
                    default: begin
                        n_pos = r_pos;
                    end
                endcase
                if (do_finish) begin
                    n_cluster = cluster_sum;
                    n_count   = count_next;
                end
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_len_size   <= 4'd0;
            r_off_size   <= 4'd0;
            r_pos        <= 3'd0;
            r_run_length <= 64'd0;
            r_delta      <= 64'd0;
            r_cluster    <= 64'd0;
            r_count      <= 15'd0;
        end else begin
            r_phase      <= n_phase;
            r_len_size   <= n_len_size;
            r_off_size   <= n_off_size;
            r_pos        <= n_pos;
            r_run_length <= n_run_length;
            r_delta      <= n_delta;
            r_cluster    <= n_cluster;
            r_count      <= n_count;
        end
    end

    // range limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    // a final result always parks the decoder
    a_final_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_res_valid && res_fin) |=> (r_phase == PH_STOPPED))
        else $error("final result did not stop the list");

    // a stopped list stays silent
    a_stopped_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_STOPPED) |-> !o_res_valid)
        else $error("result from a stopped list");

    // byte position stays inside the length field
    a_len_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_LENGTH) |-> ({1'b0, r_pos} < r_len_size))
        else $error("length byte position out of range");

    // byte position stays inside the delta field
    a_off_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_OFFSET) |-> ({1'b0, r_pos} < r_off_size))
        else $error("delta byte position out of range");

    // an emitted range never starts at cluster zero
    a_range_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (res_kind == K_RANGE)) |-> (o_res.run_start != 63'd0))
        else $error("range with zero start");

endmodule

`default_nettype wire

// ===== hdl/ntfs_rld_out_stage.sv =====
// ----------------------------------------------------------------------------
// ntfs_rld_out_stage
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ntfs_rld_out_stage (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_load,
    input  ntfs_rld_pkg::t_rld_out  i_res,
    output logic                    o_ready,
    output logic                    o_out_valid,
    input  wire                     i_out_stall,
    output ntfs_rld_pkg::t_rld_out  o_out
);
    import ntfs_rld_pkg::*;

    logic     r_valid;
    t_rld_out r_res;

    // free when empty or when the held result leaves this cycle
    assign o_ready     = !r_valid || !i_out_stall;
    assign o_out_valid = r_valid;
    assign o_out       = r_res;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ntfs_run_list_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// ntfs_run_list_decoder_unit
// NTFS data run list decoder, one run list byte per request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in): op 0 starts a new list,
//   op 1 delivers one run list byte, last marks the attribute's final byte.
//   Output channel (o_out_valid / i_out_stall / o_out): cluster ranges and
//   end, malformed and truncated markers; final_res closes the list, after
//   which bytes are dropped silently until the next start.
//   Configuration: i_cfg_we writes i_cfg_wdata into the range limit; write
//   only while the decoder is idle.
//   Path: a request waits in the input register, is decoded, and its result
//   is presented from the result register until the receiver takes it.
//   Throughput: one request per cycle while the receiver does not stall;
//   the decode path between the two registers is a byte lane insert and
//   one 64-bit cluster add.
//   Stall: while the receiver stalls a held result, the result register is
//   full and the input side stalls once its register holds a request.
//   Reset: synchronous, active low; empties both registers, clears the list
//   state and loads the range limit with 10000.
// ----------------------------------------------------------------------------
`default_nettype none

module ntfs_run_list_decoder_unit (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    output logic                    o_in_stall,
    input  ntfs_rld_pkg::t_rld_in   i_in,
    output logic                    o_out_valid,
    input  wire                     i_out_stall,
    output ntfs_rld_pkg::t_rld_out  o_out,
    input  wire                     i_cfg_we,
    input  wire  [13:0]             i_cfg_wdata
);
    import ntfs_rld_pkg::*;

    logic     item_valid;
    t_rld_in  item;
    logic     out_ready;
    logic     fire;
    logic     res_valid;
    t_rld_out res;

    // a held request is decoded when the result register has room
    assign fire = item_valid && out_ready;

    ntfs_rld_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .i_take     (fire),
        .o_valid    (item_valid),
        .o_item     (item)
    );

    ntfs_rld_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (fire),
        .i_item      (item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    ntfs_rld_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (fire && res_valid),
        .i_res       (res),
        .o_ready     (out_ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire
